FILE: rtl/sbm_pkg.sv
package sbm_pkg;

  // Configuration register indexes.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_ATTACK_KEEP = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DECAY_KEEP  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DB_RANGE    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_HEIGHT  = 2'd3;

  // Field widths.
  localparam int BIN_W   = 23;
  localparam int COL_W   = 7;
  localparam int LEVEL_W = 14;
  localparam int POW_W   = 46;
  localparam int MUL_W   = 23;

  // Arithmetic constants.
  localparam logic [17:0] DB_LOG2_Q16 = 18'd197283;
  localparam logic [15:0] FLOOR_ATT   = 16'd30720;
  localparam logic [13:0] FULL_SCALE_L = 14'd11264;

  // Divider geometry: quotient always below 2**QUO_W.
  localparam int DIVIDEND_W = 21;
  localparam int DIVISOR_W  = 7;
  localparam int QUO_W      = 14;

  typedef struct packed {
    logic mul_en;
    logic acc_clr;
    logic acc_add;
  } mul_ctrl_t;

  // Eight-bit fraction of log2(1 + idx / 2**bits), by repeated squaring.
  function automatic logic [7:0] sbm_log_frac(input int unsigned idx, input int unsigned bits);
    logic [63:0] m;
    logic [7:0]  r;
    m = ((64'd1 << bits) + 64'(idx)) << (31 - bits);
    r = '0;
    for (int k = 0; k < 8; k++) begin
      m = (m * m) >> 31;
      r = {r[6:0], 1'b0};
      if (m >= (64'd1 << 32)) begin
        m = m >> 1;
        r[0] = 1'b1;
      end
    end
    return r;
  endfunction

endpackage

FILE: rtl/sbm_if.sv
interface sbm_in_if
  import sbm_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic signed [BIN_W-1:0]  real_part;
  logic signed [BIN_W-1:0]  imag_part;
  logic        [COL_W-1:0]  column;
  logic                     last_in_band;

  modport source (output valid, real_part, imag_part, column, last_in_band, input ready);
  modport sink   (input valid, real_part, imag_part, column, last_in_band, output ready);
endinterface

interface sbm_out_if
  import sbm_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [COL_W-1:0]    out_column;
  logic [LEVEL_W-1:0]  level;

  modport source (output valid, out_column, level, input ready);
  modport sink   (input valid, out_column, level, output ready);
endinterface

FILE: rtl/sbm_mul_unit.sv
module sbm_mul_unit
  import sbm_pkg::*;
(
  input  logic             clk,
  input  mul_ctrl_t        ctrl,
  input  logic [MUL_W-1:0] op_a,
  input  logic [MUL_W-1:0] op_b,
  output logic [POW_W-1:0] prod,
  output logic [POW_W-1:0] acc
);

  logic [POW_W-1:0] prod_r;
  logic [POW_W-1:0] acc_r;

  // Product is registered before it is summed.
  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      prod_r <= op_a * op_b;
    end
    if (ctrl.acc_clr || ctrl.acc_add) begin
      acc_r <= (ctrl.acc_clr ? '0 : acc_r) + (ctrl.acc_add ? prod_r : '0);
    end
  end

  assign prod = prod_r;
  assign acc  = acc_r;

endmodule

FILE: rtl/sbm_div_unit.sv
module sbm_div_unit
  import sbm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]  divisor,
  output logic                  done,
  output logic [QUO_W-1:0]      quotient
);

  localparam int CNT_W = $clog2(QUO_W + 1);

  logic [DIVISOR_W-1:0] rem_r;
  logic [QUO_W-1:0]     shf_r;
  logic [CNT_W-1:0]     cnt_r;
  logic                 busy_r;
  logic                 done_r;
  logic [DIVISOR_W:0]   trial;
  logic [DIVISOR_W:0]   diff;
  logic                 fits;

  // Restoring division, one quotient bit a cycle. The caller guarantees
  // that the top bits of the dividend are already below the divisor.
  assign trial = {rem_r, shf_r[QUO_W-1]};
  assign fits  = trial >= {1'b0, divisor};
  assign diff  = trial - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(QUO_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= dividend[DIVIDEND_W-1:QUO_W];
      shf_r <= dividend[QUO_W-1:0];
    end else if (busy_r) begin
      rem_r <= fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
      shf_r <= {shf_r[QUO_W-2:0], fits};
    end
  end

  assign done     = done_r;
  assign quotient = shf_r;

endmodule

FILE: rtl/spectrum_band_bar_meter_unit.sv
// Channel  | Direction | Handshake        | Payload
// in_bus   | sink      | valid / ready    | real_part, imag_part, column, last_in_band
// out_bus  | source    | valid / ready    | out_column, level
// cfg      | write     | cfg_we           | cfg_idx, cfg_data
//
// A bin that does not close its band passes through acceptance, two squares on
// the shared multiplier, an accumulate and a peak compare. A closing bin goes on
// through six leading-one steps, log and dB multiply, rounding (skipped for a
// silent band or one at full scale), span multiply, divider start, divide, smoothing.
// Synchronous reset clears peak, valid bits, sequencer and output, and loads defaults.
// A finished result waits in the final state only while the output register is full.
module spectrum_band_bar_meter_unit
  import sbm_pkg::*;
#(
  parameter int NUM_COLUMNS    = 128,
  parameter int LOG_TABLE_BITS = 6
) (
  input  logic                  clk,
  input  logic                  rst_n,
  sbm_in_if.sink                in_bus,
  sbm_out_if.source             out_bus,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int IDX_W = (NUM_COLUMNS > 1) ? $clog2(NUM_COLUMNS) : 1;
  localparam logic [8:0] NCOL = 9'(NUM_COLUMNS);
  localparam int TAB_N = 2 ** LOG_TABLE_BITS;

  // Sequencer state codes.
  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_SQRE  = 5'd1;
  localparam logic [4:0] S_SQIM  = 5'd2;
  localparam logic [4:0] S_SUM   = 5'd3;
  localparam logic [4:0] S_PEAK  = 5'd4;
  localparam logic [4:0] S_NORM  = 5'd5;
  localparam logic [4:0] S_LOG   = 5'd6;
  localparam logic [4:0] S_ATT   = 5'd7;
  localparam logic [4:0] S_CLAMP = 5'd8;
  localparam logic [4:0] S_DIVI  = 5'd9;
  localparam logic [4:0] S_DIVW  = 5'd10;
  localparam logic [4:0] S_SM1   = 5'd11;
  localparam logic [4:0] S_SM2   = 5'd12;
  localparam logic [4:0] S_SM3   = 5'd13;
  localparam logic [4:0] S_SM4   = 5'd14;

  // Configuration registers.
  logic [7:0] attack_keep_r;
  logic [7:0] decay_keep_r;
  logic [6:0] db_range_r;
  logic [5:0] max_height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attack_keep_r <= 8'd26;
      decay_keep_r  <= 8'd218;
      db_range_r    <= 7'd60;
      max_height_r  <= 6'd24;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_ATTACK_KEEP: attack_keep_r <= cfg_data;
        CFG_DECAY_KEEP:  decay_keep_r  <= cfg_data;
        CFG_DB_RANGE:    db_range_r    <= cfg_data[6:0];
        CFG_MAX_HEIGHT:  max_height_r  <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  // Fraction table of the logarithm, worked out at elaboration.
  logic [7:0] log_tab [TAB_N];
  for (genvar g = 0; g < TAB_N; g++) begin : g_log_tab
    assign log_tab[g] = sbm_log_frac(g, LOG_TABLE_BITS);
  end

  // Sequencer and datapath registers.
  logic [4:0]         state_r;
  logic [BIN_W-1:0]   re_abs_r;
  logic [BIN_W-1:0]   im_abs_r;
  logic [COL_W-1:0]   col_r;
  logic               last_r;
  logic [POW_W-1:0]   peak_r;
  logic [POW_W-1:0]   norm_r;
  logic [5:0]         sh_r;
  logic [2:0]         step_r;
  logic               zero_r;
  logic [15:0]        att_r;
  logic [LEVEL_W-1:0] target_r;
  logic [LEVEL_W-1:0] old_r;
  logic [7:0]         keep_r;
  logic [IDX_W-1:0]   addr_r;

  // Output register.
  logic               out_valid_r;
  logic [COL_W-1:0]   out_column_r;
  logic [LEVEL_W-1:0] level_r;

  // Column level store with a valid bit per entry; an entry that was never
  // written since reset reads as zero.
  logic [LEVEL_W-1:0]     lvl_mem [NUM_COLUMNS];
  logic [LEVEL_W-1:0]     rdata_r;
  logic [NUM_COLUMNS-1:0] vld_r;
  logic                   mem_rd;
  logic                   mem_wr;

  // Shared multiplier.
  mul_ctrl_t        mctl;
  logic [MUL_W-1:0] mul_a;
  logic [MUL_W-1:0] mul_b;
  logic [POW_W-1:0] prod;
  logic [POW_W-1:0] acc;

  sbm_mul_unit u_mul (
    .clk  (clk),
    .ctrl (mctl),
    .op_a (mul_a),
    .op_b (mul_b),
    .prod (prod),
    .acc  (acc)
  );

  // Divider for the bar height.
  logic             div_start;
  logic             div_done;
  logic [QUO_W-1:0] quotient;
  logic [6:0]       range_eff;

  assign range_eff = (db_range_r == 7'd0) ? 7'd1 : db_range_r;

  sbm_div_unit u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (prod[DIVIDEND_W-1:0]),
    .divisor  (range_eff),
    .done     (div_done),
    .quotient (quotient)
  );

  // Combinational helpers.
  logic [POW_W-1:0]   pwr;
  logic [POW_W-1:0]   pk;
  logic [8:0]         col9;
  logic               col_ok;
  logic               top_zero;
  logic [POW_W-1:0]   shifted;
  logic [5:0]         sh_inc;
  logic [5:0]         expo;
  logic [13:0]        lq8;
  logic [13:0]        n_q8;
  logic [32:0]        rnd;
  logic [16:0]        att_raw;
  logic [14:0]        r15;
  logic [14:0]        att_c;
  logic [14:0]        dspan;
  logic [8:0]         keep_inv;
  logic [7:0]         keep_sel;
  logic [22:0]        sm_sum;
  logic [LEVEL_W-1:0] new_level;
  logic               out_free;
  logic [BIN_W-1:0]   re_in;
  logic [BIN_W-1:0]   im_in;

  assign re_in  = in_bus.real_part;
  assign im_in  = in_bus.imag_part;
  assign pwr    = acc;
  assign pk     = (pwr > peak_r) ? pwr : peak_r;
  assign col9   = {2'b00, col_r};
  assign col_ok = col9 < NCOL;

  // One stage of the leading-one search: shift out 32, 16, 8, 4, 2, 1 bits
  // of leading zeros in turn.
  always_comb begin
    case (step_r)
      3'd0: begin
        top_zero = (norm_r[45:14] == '0);
        shifted  = norm_r << 32;
        sh_inc   = 6'd32;
      end
      3'd1: begin
        top_zero = (norm_r[45:30] == '0);
        shifted  = norm_r << 16;
        sh_inc   = 6'd16;
      end
      3'd2: begin
        top_zero = (norm_r[45:38] == '0);
        shifted  = norm_r << 8;
        sh_inc   = 6'd8;
      end
      3'd3: begin
        top_zero = (norm_r[45:42] == '0);
        shifted  = norm_r << 4;
        sh_inc   = 6'd4;
      end
      3'd4: begin
        top_zero = (norm_r[45:44] == '0);
        shifted  = norm_r << 2;
        sh_inc   = 6'd2;
      end
      3'd5: begin
        top_zero = ~norm_r[45];
        shifted  = norm_r << 1;
        sh_inc   = 6'd1;
      end
      default: begin
        top_zero = 1'b0;
        shifted  = norm_r;
        sh_inc   = 6'd0;
      end
    endcase
  end

  // Log2 in Q.8: the exponent above the fraction from the table.
  assign expo = 6'd45 - sh_r;
  assign lq8  = {expo, log_tab[norm_r[POW_W-2 -: LOG_TABLE_BITS]]};
  // Distance below full scale, fed straight into the dB multiply.
  assign n_q8 = FULL_SCALE_L - lq8;

  // Attenuation from the dB product, rounded and limited to the floor.
  assign rnd     = {1'b0, prod[31:0]} + 33'd32768;
  assign att_raw = rnd[32:16];

  // Span left above the clamped attenuation.
  assign r15   = {range_eff, 8'd0};
  assign att_c = (att_r > {1'b0, r15}) ? r15 : att_r[14:0];
  assign dspan = r15 - att_c;

  // Smoothing weights and the rounded blend.
  assign keep_sel  = (target_r > old_r) ? attack_keep_r : decay_keep_r;
  assign keep_inv  = 9'd256 - {1'b0, keep_r};
  assign sm_sum    = acc[22:0] + 23'd128;
  assign new_level = sm_sum[21:8];

  assign out_free = !out_valid_r || out_bus.ready;

  // Operand selection for the shared multiplier.
  always_comb begin
    mctl  = '0;
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_SQRE: begin
        mctl.mul_en = 1'b1;
        mul_a       = re_abs_r;
        mul_b       = re_abs_r;
      end
      S_SQIM: begin
        mctl.mul_en  = 1'b1;
        mctl.acc_clr = 1'b1;
        mctl.acc_add = 1'b1;
        mul_a        = im_abs_r;
        mul_b        = im_abs_r;
      end
      S_SUM: begin
        mctl.acc_add = 1'b1;
      end
      S_LOG: begin
        mctl.mul_en = 1'b1;
        mul_a       = {9'd0, n_q8};
        mul_b       = {5'd0, DB_LOG2_Q16};
      end
      S_CLAMP: begin
        mctl.mul_en = 1'b1;
        mul_a       = {17'd0, max_height_r};
        mul_b       = {8'd0, dspan};
      end
      S_SM1: begin
        mctl.mul_en = 1'b1;
        mul_a       = {9'd0, old_r};
        mul_b       = {15'd0, keep_sel};
      end
      S_SM2: begin
        mctl.mul_en  = 1'b1;
        mctl.acc_clr = 1'b1;
        mctl.acc_add = 1'b1;
        mul_a        = {9'd0, target_r};
        mul_b        = {14'd0, keep_inv};
      end
      S_SM3: begin
        mctl.acc_add = 1'b1;
      end
      default: ;
    endcase
  end

  assign div_start = (state_r == S_DIVI);
  assign mem_rd    = (state_r == S_PEAK) && last_r && col_ok;
  assign mem_wr    = (state_r == S_SM4) && out_free;

  // Sequencer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      peak_r  <= '0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_bus.valid) begin
            state_r <= S_SQRE;
          end
        end
        S_SQRE:  state_r <= S_SQIM;
        S_SQIM:  state_r <= S_SUM;
        S_SUM:   state_r <= S_PEAK;
        S_PEAK: begin
          if (!last_r) begin
            peak_r  <= pk;
            state_r <= S_IDLE;
          end else begin
            peak_r  <= '0;
            state_r <= col_ok ? S_NORM : S_IDLE;
          end
        end
        S_NORM: begin
          if (step_r == 3'd5) begin
            state_r <= S_LOG;
          end
        end
        S_LOG: begin
          if (zero_r || (lq8 >= FULL_SCALE_L)) begin
            state_r <= S_CLAMP;
          end else begin
            state_r <= S_ATT;
          end
        end
        S_ATT:   state_r <= S_CLAMP;
        S_CLAMP: state_r <= S_DIVI;
        S_DIVI:  state_r <= S_DIVW;
        S_DIVW: begin
          if (div_done) begin
            state_r <= S_SM1;
          end
        end
        S_SM1:   state_r <= S_SM2;
        S_SM2:   state_r <= S_SM3;
        S_SM3:   state_r <= S_SM4;
        S_SM4: begin
          if (out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Datapath registers without reset.
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        re_abs_r <= re_in[BIN_W-1] ? (~re_in + 1'b1) : re_in;
        im_abs_r <= im_in[BIN_W-1] ? (~im_in + 1'b1) : im_in;
        col_r    <= in_bus.column;
        last_r   <= in_bus.last_in_band;
      end
      S_PEAK: begin
        norm_r <= pk;
        zero_r <= (pk == '0);
        sh_r   <= '0;
        step_r <= '0;
        addr_r <= col9[IDX_W-1:0];
      end
      S_NORM: begin
        step_r <= step_r + 1'b1;
        if (top_zero) begin
          norm_r <= shifted;
          sh_r   <= sh_r + sh_inc;
        end
      end
      S_LOG: begin
        if (zero_r) begin
          att_r <= FLOOR_ATT;
        end else if (lq8 >= FULL_SCALE_L) begin
          att_r <= '0;
        end
      end
      S_ATT: begin
        att_r <= (att_raw > {1'b0, FLOOR_ATT}) ? FLOOR_ATT : att_raw[15:0];
      end
      S_DIVW: begin
        target_r <= quotient;
        old_r    <= vld_r[addr_r] ? rdata_r : '0;
      end
      S_SM1: begin
        keep_r <= keep_sel;
      end
      default: ;
    endcase
  end

  // Level store: registered read, single write port.
  always_ff @(posedge clk) begin
    if (mem_rd) begin
      rdata_r <= lvl_mem[col9[IDX_W-1:0]];
    end
    if (mem_wr) begin
      lvl_mem[addr_r] <= new_level;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (mem_wr) begin
      vld_r[addr_r] <= 1'b1;
    end
  end

  // Output register: loaded with a finished result, cleared when taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (mem_wr) begin
      out_valid_r <= 1'b1;
    end else if (out_bus.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_wr) begin
      out_column_r <= col_r;
      level_r      <= new_level;
    end
  end

  assign in_bus.ready       = (state_r == S_IDLE);
  assign out_bus.valid      = out_valid_r;
  assign out_bus.out_column = out_column_r;
  assign out_bus.level      = level_r;

endmodule

FILE: sim/sbm_level_monitor.sv
module sbm_level_monitor
  import sbm_pkg::*;
#(
  parameter int NUM_COLUMNS    = 128,
  parameter int LOG_TABLE_BITS = 6
) (
  input  logic                  clk,
  input  logic                  rst_n,
  sbm_in_if                     in_mon,
  sbm_out_if                    out_mon,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    mismatches,
  output int                    outstanding
);

  localparam int unsigned FULL_SCALE_Q8     = 44 * 256;
  localparam int unsigned ATT_FLOOR_Q8      = 120 * 256;
  localparam longint unsigned DB_PER_OCTAVE = 64'd197283;

  typedef struct packed {
    logic [COL_W-1:0]   column;
    logic [LEVEL_W-1:0] level;
  } level_report_t;

  logic [POW_W-1:0]   open_peak;
  logic [LEVEL_W-1:0] bar_level [NUM_COLUMNS];
  logic [7:0]         attack_keep_q8;
  logic [7:0]         decay_keep_q8;
  logic [6:0]         span_db;
  logic [5:0]         full_height;
  level_report_t      due_reports [$];
  int                 fail_tally = 0;

  assign mismatches = fail_tally;

  // Fraction of log2(1 + idx / 2**LOG_TABLE_BITS) in eight bits: each round
  // squares a Q1.31 mantissa and takes the carry above the binary point.
  function automatic logic [7:0] log2_fraction(input int unsigned idx);
    logic [63:0] m;
    logic [7:0]  f;
    int          k;
    m = ((64'd1 << LOG_TABLE_BITS) + 64'(idx)) << (31 - LOG_TABLE_BITS);
    f = '0;
    for (k = 0; k < 8; k++) begin
      m = (m * m) >> 31;
      f = {f[6:0], m[32]};
      if (m[32]) begin
        m = m >> 1;
      end
    end
    return f;
  endfunction

  // Attenuation below full scale in Q.8 dB, limited to the silence floor.
  function automatic int unsigned atten_q8(input logic [POW_W-1:0] pw);
    int unsigned      msb;
    int unsigned      lq8;
    logic [POW_W-1:0] aligned;
    longint unsigned  att;
    int               b;
    if (pw == '0) begin
      return ATT_FLOOR_Q8;
    end
    msb = 0;
    for (b = 0; b < POW_W; b++) begin
      if (pw[b]) begin
        msb = b;
      end
    end
    if (msb >= LOG_TABLE_BITS) begin
      aligned = pw >> (msb - LOG_TABLE_BITS);
    end else begin
      aligned = pw << (LOG_TABLE_BITS - msb);
    end
    lq8 = msb * 256 + 32'(log2_fraction(32'(aligned[LOG_TABLE_BITS-1:0])));
    if (lq8 >= FULL_SCALE_Q8) begin
      return 0;
    end
    att = (64'(FULL_SCALE_Q8 - lq8) * DB_PER_OCTAVE + 64'd32768) >> 16;
    if (att > 64'(ATT_FLOOR_Q8)) begin
      att = 64'(ATT_FLOOR_Q8);
    end
    return 32'(att);
  endfunction

  // Folds one bin into the open band; on a closing bin with a column in range it
  // returns 1 with the new smoothed level of the column.
  function automatic bit fold_bin(input logic signed [BIN_W-1:0] re,
                                  input logic signed [BIN_W-1:0] im,
                                  input logic [COL_W-1:0] col,
                                  input logic last,
                                  output level_report_t rep);
    longint           sq;
    logic [POW_W-1:0] pw;
    int unsigned      span_q8;
    int unsigned      att;
    int unsigned      target;
    int unsigned      old_lvl;
    int unsigned      keep;
    int unsigned      nxt;
    longint unsigned  num;
    rep = '0;
    sq = longint'(re) * longint'(re) + longint'(im) * longint'(im);
    pw = sq[POW_W-1:0];
    if (pw > open_peak) begin
      open_peak = pw;
    end
    if (!last) begin
      return 0;
    end
    pw = open_peak;
    open_peak = '0;
    if (int'(col) >= NUM_COLUMNS) begin
      return 0;
    end
    // A zero span is taken as one dB.
    span_q8 = (span_db == '0) ? 256 : 32'(span_db) * 256;
    att = atten_q8(pw);
    if (att > span_q8) begin
      att = span_q8;
    end
    num = 64'(full_height) * 64'd256 * 64'(span_q8 - att);
    target = 32'(num / 64'(span_q8));
    old_lvl = 32'(bar_level[col]);
    keep = (target > old_lvl) ? 32'(attack_keep_q8) : 32'(decay_keep_q8);
    nxt = (old_lvl * keep + target * (256 - keep) + 128) >> 8;
    bar_level[col] = nxt[LEVEL_W-1:0];
    rep.column = col;
    rep.level = nxt[LEVEL_W-1:0];
    return 1;
  endfunction

  task automatic record_failure(input string what);
    fail_tally++;
    if (fail_tally <= 10) begin
      $display("%0t: %s", $time, what);
    end
  endtask

  always @(posedge clk) begin
    level_report_t seen;
    level_report_t due;
    level_report_t fresh;
    if (!rst_n) begin
      open_peak = '0;
      foreach (bar_level[c]) begin
        bar_level[c] = '0;
      end
      attack_keep_q8 = 8'd26;
      decay_keep_q8 = 8'd218;
      span_db = 7'd60;
      full_height = 6'd24;
      due_reports.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          CFG_ATTACK_KEEP: attack_keep_q8 = cfg_data;
          CFG_DECAY_KEEP:  decay_keep_q8 = cfg_data;
          CFG_DB_RANGE:    span_db = cfg_data[6:0];
          CFG_MAX_HEIGHT:  full_height = cfg_data[5:0];
          default: ;
        endcase
      end
      // A result can never stem from a bin taken at the same edge, so the
      // result is checked before the new bin is folded in.
      if (out_mon.valid && out_mon.ready) begin
        seen.column = out_mon.out_column;
        seen.level = out_mon.level;
        if (due_reports.size() == 0) begin
          record_failure($sformatf("unexpected result: column %0d level %0d",
                                   seen.column, seen.level));
        end else begin
          due = due_reports.pop_front();
          if (seen.column !== due.column || seen.level !== due.level) begin
            record_failure($sformatf(
              "level mismatch: expected column %0d level %0d, got column %0d level %0d",
              due.column, due.level, seen.column, seen.level));
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        if (fold_bin(in_mon.real_part, in_mon.imag_part, in_mon.column,
                     in_mon.last_in_band, fresh)) begin
          due_reports.push_back(fresh);
        end
      end
    end
    outstanding <= due_reports.size();
  end

endmodule

FILE: sim/tb.sv
module tb;
  import sbm_pkg::*;

  // A bin that does not close its band leaves no result behind, so the drain
  // wait covers the closing latency of the block plus some margin for the
  // output register.
  localparam int DRAIN_CYCLES = 60;
  localparam int PHASE_BINS   = 175;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    mismatches;
  int                    outstanding;

  // When set, both sides run without idling for a stretch of bands.
  bit steady = 1'b0;

  sbm_in_if  in_bus ();
  sbm_out_if out_bus ();

  spectrum_band_bar_meter_unit #(
    .NUM_COLUMNS    (128),
    .LOG_TABLE_BITS (6)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_bus   (in_bus),
    .out_bus  (out_bus),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  // The monitor sees the same channels and register writes as the block,
  // keeps its own copy of the meter state and compares every level reported.
  sbm_level_monitor #(
    .NUM_COLUMNS    (128),
    .LOG_TABLE_BITS (6)
  ) level_mon (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (in_bus),
    .out_mon     (out_bus),
    .cfg_we      (cfg_we),
    .cfg_idx     (cfg_idx),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Each side draws a random wait before each item, except in steady runs.
  function automatic int draw_wait();
    return steady ? 0 : $urandom_range(0, 15);
  endfunction

  // One bin component. Most values get a random bit length so that the peak
  // powers spread over the whole dB scale instead of sitting near full scale.
  function automatic int rand_part();
    int mag;
    int bits;
    case ($urandom_range(0, 7))
      0: return ($urandom_range(0, 1) != 0) ? 4194303 : -4194304;
      1: return int'($urandom_range(0, 8388607)) - 4194304;
      default: begin
        bits = $urandom_range(0, 22);
        mag = int'($urandom & ((32'd1 << bits) - 32'd1));
        return ($urandom_range(0, 1) != 0) ? -mag : mag;
      end
    endcase
  endfunction

  // Offers one bin and returns just after the edge at which it was taken.
  // With no gap the valid stays high, so it is never lowered and raised again
  // within one time step.
  task automatic send_bin(input int re, input int im, input int col, input bit last);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid        <= 1'b1;
    in_bus.real_part    <= re[BIN_W-1:0];
    in_bus.imag_part    <= im[BIN_W-1:0];
    in_bus.column       <= col[COL_W-1:0];
    in_bus.last_in_band <= last;
    do @(posedge clk); while (!in_bus.ready);
  endtask

  // Waits until every expected level has come back, then lets the block
  // finish any bin that could not produce a result.
  task automatic drain();
    in_bus.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= value[CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_we   <= 1'b0;
  endtask

  // The result side: a random stall before each item, then ready stays high
  // until the block hands one over. The first pass drives ready at time zero
  // either way.
  initial begin
    int stall;
    forever begin
      stall = draw_wait();
      if (stall > 0) begin
        out_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_bus.ready <= 1'b1;
      do @(posedge clk); while (!out_bus.valid);
    end
  end

  initial begin
    int ph;
    int j;
    int sent;
    int band_len;
    int band_col;
    int a_k;
    int d_k;
    int span;
    int height;
    rst_n               <= 1'b0;
    cfg_we              <= 1'b0;
    cfg_idx             <= '0;
    cfg_data            <= '0;
    in_bus.valid        <= 1'b0;
    in_bus.real_part    <= '0;
    in_bus.imag_part    <= '0;
    in_bus.column       <= '0;
    in_bus.last_in_band <= 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed bins under the reset register values.
    // Zero power falls to the silence floor.
    send_bin(0, 0, 0, 1'b1);
    // Both parts at the negative extreme: power above full scale.
    send_bin(-4194304, -4194304, 127, 1'b1);
    // Largest positive real part alone: just under full scale.
    send_bin(4194303, 0, 1, 1'b1);
    // Power of exactly full scale.
    send_bin(0, -4194304, 2, 1'b1);
    // The smallest non-zero powers, where the log index is filled from the right.
    send_bin(1, 0, 3, 1'b1);
    send_bin(0, -1, 3, 1'b1);
    // The peak of the band sits on a middle bin.
    send_bin(1000, -2000, 90, 1'b0);
    send_bin(-300000, 120000, 91, 1'b0);
    send_bin(5, 5, 92, 1'b0);
    send_bin(7, -9, 4, 1'b1);
    // The closing bin carries the peak; the other bins name a different column.
    send_bin(10, 10, 20, 1'b0);
    send_bin(50, 50, 20, 1'b0);
    send_bin(2000000, -1500000, 21, 1'b1);
    // One column driven up twice with fast attack, then let down with slow decay.
    send_bin(4000000, 0, 6, 1'b1);
    send_bin(4000000, 0, 6, 1'b1);
    send_bin(0, 0, 6, 1'b1);
    send_bin(0, 0, 6, 1'b1);
    // All-ones parts on an open bin, closed by a silent bin.
    send_bin(-1, -1, 0, 1'b0);
    send_bin(0, 0, 0, 1'b1);
    send_bin(4194303, 4194303, 64, 1'b1);

    // Random phases, each under its own register setting. The first ones take
    // the extremes, among them the zero dB span that the block treats as one dB.
    for (ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin a_k = 0;   d_k = 255; span = 0;   height = 63; end
        1: begin a_k = 255; d_k = 0;   span = 127; height = 1;  end
        2: begin a_k = 26;  d_k = 218; span = 60;  height = 24; end
        3: begin a_k = 128; d_k = 128; span = 1;   height = 63; end
        4: begin a_k = 255; d_k = 255; span = 120; height = 0;  end
        5: begin a_k = 0;   d_k = 0;   span = 120; height = 63; end
        default: begin
          a_k = $urandom_range(0, 255);
          d_k = $urandom_range(0, 255);
          span = $urandom_range(1, 120);
          height = $urandom_range(1, 63);
        end
      endcase
      drain();
      write_reg(CFG_ATTACK_KEEP, a_k);
      write_reg(CFG_DECAY_KEEP, d_k);
      write_reg(CFG_DB_RANGE, span);
      write_reg(CFG_MAX_HEIGHT, height);
      @(posedge clk);

      sent = 0;
      while (sent < PHASE_BINS) begin
        if ($urandom_range(0, 39) == 0) begin
          steady = !steady;
        end
        // Mostly short bands so that results come often; now and then a long one.
        band_len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 4);
        // A handful of columns get most bands, so their levels build a history.
        band_col = ($urandom_range(0, 9) < 6) ? $urandom_range(0, 3) : $urandom_range(0, 127);
        for (j = 0; j < band_len; j++) begin
          if (j == band_len - 1) begin
            send_bin(rand_part(), rand_part(), band_col, 1'b1);
          end else begin
            // The column of an open bin is ignored, so it carries noise.
            send_bin(rand_part(), rand_part(), $urandom_range(0, 127), 1'b0);
          end
        end
        sent += band_len;
      end
    end

    drain();
    if (mismatches == 0 && outstanding == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Far beyond the slowest correct run: every item waiting out the longest
  // gap, the block's closing latency and the longest result stall.
  initial begin
    #6000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
